>>> src/e2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared types and constants for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

  localparam int IN_W  = 32;
  localparam int OUT_W = 48;

  // Reciprocals for the constant divisions. Divide by 60 as (n >> 2) / 15 with
  // a 35-bit shift, by 24 as (n >> 3) / 3 with a 33-bit shift, by 7 with a
  // 20-bit shift (dividend below 2^17).
  localparam logic [31:0] RECIP_15 = 32'h8888_8889;
  localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP_7  = 32'd149797;

  localparam logic [31:0] DAYS_PER_WEEK  = 32'd7;
  localparam logic [31:0] EPOCH_WDAY     = 32'd4;
  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [15:0] DAYS_PER_QUAD  = 16'd1461;
  localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
  localparam logic [8:0]  DAYS_YEAR      = 9'd365;
  localparam logic [3:0]  MON_FEB        = 4'd1;

  typedef enum logic [1:0] {
    OP_SEC,
    OP_MIN,
    OP_HOUR,
    OP_WDAY
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEC_MUL,
    ST_SEC_REM,
    ST_MIN_MUL,
    ST_MIN_REM,
    ST_HOUR_MUL,
    ST_HOUR_REM,
    ST_WDAY_MUL,
    ST_WDAY_REM,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    start;
    div_op_t div_op;
    logic    div_mul;
    logic    div_rem;
    logic    yr_step;
    logic    mon_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic yr_done;
    logic mon_done;
    logic out_free;
  } sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> src/e2c_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_ctrl
// Sequencer: runs the constant divisions, the year walk and the month walk,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module e2c_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  e2c_pkg::sts_t sts,
  output e2c_pkg::cmd_t cmd
);

  e2c_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= e2c_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.div_op   = e2c_pkg::OP_SEC;
    in_tready    = 1'b0;
    case (state_r)
      e2c_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = e2c_pkg::ST_SEC_MUL;
        end
      end
      e2c_pkg::ST_SEC_MUL: begin
        cmd.div_mul = 1'b1;
        cmd.div_op  = e2c_pkg::OP_SEC;
        state_nxt   = e2c_pkg::ST_SEC_REM;
      end
      e2c_pkg::ST_SEC_REM: begin
        cmd.div_rem = 1'b1;
        cmd.div_op  = e2c_pkg::OP_SEC;
        state_nxt   = e2c_pkg::ST_MIN_MUL;
      end
      e2c_pkg::ST_MIN_MUL: begin
        cmd.div_mul = 1'b1;
        cmd.div_op  = e2c_pkg::OP_MIN;
        state_nxt   = e2c_pkg::ST_MIN_REM;
      end
      e2c_pkg::ST_MIN_REM: begin
        cmd.div_rem = 1'b1;
        cmd.div_op  = e2c_pkg::OP_MIN;
        state_nxt   = e2c_pkg::ST_HOUR_MUL;
      end
      e2c_pkg::ST_HOUR_MUL: begin
        cmd.div_mul = 1'b1;
        cmd.div_op  = e2c_pkg::OP_HOUR;
        state_nxt   = e2c_pkg::ST_HOUR_REM;
      end
      e2c_pkg::ST_HOUR_REM: begin
        cmd.div_rem = 1'b1;
        cmd.div_op  = e2c_pkg::OP_HOUR;
        state_nxt   = e2c_pkg::ST_WDAY_MUL;
      end
      e2c_pkg::ST_WDAY_MUL: begin
        cmd.div_mul = 1'b1;
        cmd.div_op  = e2c_pkg::OP_WDAY;
        state_nxt   = e2c_pkg::ST_WDAY_REM;
      end
      e2c_pkg::ST_WDAY_REM: begin
        cmd.div_rem = 1'b1;
        cmd.div_op  = e2c_pkg::OP_WDAY;
        state_nxt   = e2c_pkg::ST_YEAR;
      end
      e2c_pkg::ST_YEAR: begin
        cmd.yr_step = 1'b1;
        if (sts.yr_done) state_nxt = e2c_pkg::ST_MONTH;
      end
      e2c_pkg::ST_MONTH: begin
        cmd.mon_step = 1'b1;
        if (sts.mon_done) state_nxt = e2c_pkg::ST_DONE;
      end
      e2c_pkg::ST_DONE: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = e2c_pkg::ST_IDLE;
        end
      end
      default: state_nxt = e2c_pkg::ST_IDLE;
    endcase
  end

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register is stalled");

  a_year_after_wday: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == e2c_pkg::ST_YEAR) && $past(state_r) != e2c_pkg::ST_YEAR
      |-> $past(state_r) == e2c_pkg::ST_WDAY_REM)
    else $error("year walk entered before weekday division finished");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == e2c_pkg::ST_SEC_MUL)
    else $error("new request did not start the seconds division");

endmodule

>>> src/e2c_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_dp
// Datapath: reciprocal-multiply constant divider, year and month walkers,
// and the output register.
// ----------------------------------------------------------------------------
module e2c_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [e2c_pkg::IN_W-1:0]     in_tdata,
  input  e2c_pkg::cmd_t                cmd,
  output e2c_pkg::sts_t                sts,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [e2c_pkg::OUT_W-1:0]    out_tdata
);

  // divider
  logic [31:0] num_r, num_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] mul_a;
  logic [31:0] mul_m;
  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] qd;
  logic [31:0] rem;

  // calendar fields
  logic [15:0] days_r, days_nxt;
  logic [11:0] yr_r, yr_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [4:0]  hrs_r, hrs_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [2:0]  wd_r, wd_nxt;

  logic        leap;
  logic [8:0]  ylen;
  logic        quad_ge;
  logic        year_ge;
  logic [4:0]  mlen;
  logic        mon_ge;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [e2c_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  // pre-shift the dividend and pick the reciprocal
  always_comb begin
    case (cmd.div_op)
      e2c_pkg::OP_SEC, e2c_pkg::OP_MIN: begin
        mul_a = {2'd0, num_r[31:2]};
        mul_m = e2c_pkg::RECIP_15;
      end
      e2c_pkg::OP_HOUR: begin
        mul_a = {3'd0, num_r[31:3]};
        mul_m = e2c_pkg::RECIP_3;
      end
      e2c_pkg::OP_WDAY: begin
        mul_a = num_r;
        mul_m = e2c_pkg::RECIP_7;
      end
      default: begin
        mul_a = num_r;
        mul_m = '0;
      end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_m};

  // quotient from the product, and the registered quotient times the divisor
  always_comb begin
    case (cmd.div_op)
      e2c_pkg::OP_SEC, e2c_pkg::OP_MIN: begin
        quo = {3'd0, prod[63:35]};
        qd  = {quo_r[25:0], 6'd0} - {quo_r[29:0], 2'd0};
      end
      e2c_pkg::OP_HOUR: begin
        quo = {1'b0, prod[63:33]};
        qd  = {quo_r[27:0], 4'd0} + {quo_r[28:0], 3'd0};
      end
      e2c_pkg::OP_WDAY: begin
        quo = prod[51:20];
        qd  = {quo_r[28:0], 3'd0} - quo_r;
      end
      default: begin
        quo = '0;
        qd  = '0;
      end
    endcase
  end

  assign rem = num_r - qd;

  assign leap    = (yr_r[1:0] == 2'b00);
  assign ylen    = leap ? e2c_pkg::DAYS_LEAP_YEAR : e2c_pkg::DAYS_YEAR;
  assign quad_ge = days_r >= e2c_pkg::DAYS_PER_QUAD;
  assign year_ge = days_r >= {7'd0, ylen};
  assign mlen    = e2c_pkg::month_len(mon_r, leap);
  assign mon_ge  = days_r >= {11'd0, mlen};

  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    days_nxt = days_r;
    yr_nxt   = yr_r;
    mon_nxt  = mon_r;
    hrs_nxt  = hrs_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    wd_nxt   = wd_r;

    if (cmd.start) begin
      num_nxt = in_tdata;
      yr_nxt  = e2c_pkg::EPOCH_YEAR;
      mon_nxt = '0;
    end

    if (cmd.div_mul) begin
      quo_nxt = quo;
    end

    // take the remainder as a field, the quotient as the next dividend
    if (cmd.div_rem) begin
      num_nxt = quo_r;
      case (cmd.div_op)
        e2c_pkg::OP_SEC: begin
          sec_nxt = rem[5:0];
        end
        e2c_pkg::OP_MIN: begin
          min_nxt = rem[5:0];
        end
        e2c_pkg::OP_HOUR: begin
          hrs_nxt  = rem[4:0];
          days_nxt = quo_r[15:0];
          num_nxt  = quo_r + e2c_pkg::EPOCH_WDAY;
        end
        e2c_pkg::OP_WDAY: begin
          wd_nxt = rem[2:0];
        end
        default: begin
          num_nxt = quo_r;
        end
      endcase
    end

    // strip four-year blocks first, then single years
    if (cmd.yr_step) begin
      if (quad_ge) begin
        days_nxt = days_r - e2c_pkg::DAYS_PER_QUAD;
        yr_nxt   = yr_r + 12'd4;
      end else if (year_ge) begin
        days_nxt = days_r - {7'd0, ylen};
        yr_nxt   = yr_r + 12'd1;
      end
    end

    if (cmd.mon_step && mon_ge) begin
      days_nxt = days_r - {11'd0, mlen};
      mon_nxt  = mon_r + 4'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'd0,
                       yr_r,
                       mon_r + 4'd1,
                       wd_r,
                       days_r[4:0] + 5'd1,
                       hrs_r,
                       min_r,
                       sec_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    quo_r      <= quo_nxt;
    days_r     <= days_nxt;
    yr_r       <= yr_nxt;
    mon_r      <= mon_nxt;
    hrs_r      <= hrs_nxt;
    min_r      <= min_nxt;
    sec_r      <= sec_nxt;
    wd_r       <= wd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.yr_done  = !quad_ge && !year_ge;
  assign sts.mon_done = !mon_ge;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_days_fit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_rem && cmd.div_op == e2c_pkg::OP_HOUR |-> quo_r[31:16] == 16'd0)
    else $error("day count overflows its register");

  a_wday_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_rem && cmd.div_op == e2c_pkg::OP_WDAY |-> rem < e2c_pkg::DAYS_PER_WEEK)
    else $error("weekday remainder out of range");

  a_year_left: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.yr_step && sts.yr_done |-> days_r < 16'd366)
    else $error("year walk ended with more than a year left");

  a_month_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> mon_r < 4'd12 && days_r < 16'd31)
    else $error("month walk ended out of range");

endmodule

>>> src/epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts seconds since 1970-01-01 00:00:00 into time of day, weekday and
// calendar date.
// ----------------------------------------------------------------------------
// One request is converted at a time. Seconds, minutes, hours and the day
// count come from constant divisions by 60, 60 and 24, and the weekday from
// a division by 7; each is a reciprocal multiplication and then a remainder
// step. A year walk then strips four-year blocks and single years, a month
// walk strips whole months, and the result is loaded into the output register
// once it is free. Every year divisible by four is a leap year, so 2100 counts
// as one. A new request is taken the cycle after the load, while the last
// result may still wait on the output side.
module epoch_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [5:0] seconds, [11:6] minutes, [16:12] hours,
                                  // [21:17] day_of_month, [24:22] weekday,
                                  // [28:25] month_number, [40:29] year_number
);

  e2c_pkg::cmd_t cmd;
  e2c_pkg::sts_t sts;

  e2c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  e2c_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/tb_epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_top
// Self-checking bench for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
// Requests go in on the input stream and each accepted one is converted by
// a behavioral calendar model. The resulting date is queued, and every result
// that leaves the block is compared field by field with the oldest entry.
// Stimulus runs from hand-picked dates (field extremes, year and leap-day
// edges, the year 2100 leap rule, all-ones input) through random epochs and
// day-boundary times, with random gaps and stalls, a long output hold-off, a
// full drain, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_top;

  localparam int HOLD_OFF_CYCLES = 600;
  localparam int STALL_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 200;

  // Result fields as packed on out_tdata[40:0], first field in the high bits
  typedef struct packed {
    logic [11:0] year_number;
    logic [3:0]  month_number;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } cal_date_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  cal_date_t   expected_dates[$];
  int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  bit          hold_off_pending = 1'b0;

  epoch_seconds_to_calendar_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cal_date_t calendar_of(input logic [31:0] epoch);
    cal_date_t   d;
    int unsigned t;
    int unsigned days;
    int unsigned yr;
    int unsigned ylen;
    int unsigned mon;
    int unsigned mlen;
    t = epoch;
    d.seconds = 6'(t % 60);
    t = t / 60;
    d.minutes = 6'(t % 60);
    t = t / 60;
    d.hours = 5'(t % 24);
    days = t / 24;
    d.weekday = 3'((days + 4) % 7);
    // Every fourth year is leap, 2100 included
    yr = 1970;
    ylen = 365;
    while (days >= ylen) begin
      days = days - ylen;
      yr = yr + 1;
      ylen = (yr % 4 == 0) ? 366 : 365;
    end
    mon = 0;
    mlen = month_days[0];
    while (mon < 11 && days >= mlen) begin
      days = days - mlen;
      mon = mon + 1;
      mlen = (mon == 1 && yr % 4 == 0) ? 29 : month_days[mon];
    end
    d.day_of_month = 5'(days + 1);
    d.month_number = 4'(mon + 1);
    d.year_number  = 12'(yr);
    return d;
  endfunction

  // Record each accepted request's expected date
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_dates.push_back(calendar_of(in_tdata));
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    cal_date_t want;
    cal_date_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = cal_date_t'(out_tdata[40:0]);
      if (expected_dates.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %h",
                 $time, out_tdata);
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("seconds", want.seconds, got.seconds);
        check_field("minutes", want.minutes, got.minutes);
        check_field("hours", want.hours, got.hours);
        check_field("day_of_month", want.day_of_month, got.day_of_month);
        check_field("weekday", want.weekday, got.weekday);
        check_field("month_number", want.month_number, got.month_number);
        check_field("year_number", want.year_number, got.year_number);
        check_field("padding", 0, out_tdata[47:41]);
      end
    end
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_epoch(input logic [31:0] epoch);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= epoch;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    while (expected_dates.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_epoch(32'd0);
    send_epoch(32'd1);
    send_epoch(32'd59);
    send_epoch(32'd60);
    send_epoch(32'd3599);
    send_epoch(32'd3600);
    send_epoch(32'd86399);
    send_epoch(32'd86400);
    send_epoch(32'd31535999);    // last second of 1970
    send_epoch(32'd31536000);
    send_epoch(32'd68169600);    // 1972-02-29
    send_epoch(32'd94694399);    // last second of a leap year
    send_epoch(32'd951782400);   // 2000-02-29
    send_epoch(32'd4102444799);  // last second of 2099
    send_epoch(32'd4107542400);  // Feb 29 of 2100 under the divide-by-four rule
    send_epoch(32'd4107628800);
    send_epoch(32'h7FFF_FFFF);
    send_epoch(32'h8000_0000);
    send_epoch(32'h5555_5555);
    send_epoch(32'hAAAA_AAAA);
    send_epoch(32'hFFFF_FFFF);
  endtask

  task automatic test_random_epochs(input int count);
    repeat (count) send_epoch($urandom);
  endtask

  // Land on the first or last second of a day, or a random time of day, to hit month and year edges
  task automatic test_day_edges(input int count);
    longint unsigned day;
    longint unsigned tod;
    repeat (count) begin
      day = $urandom_range(0, 49709);
      case ($urandom_range(0, 2))
        0:       tod = 0;
        1:       tod = 86399;
        default: tod = $urandom_range(0, 86399);
      endcase
      send_epoch(32'(day * 86400 + tod));
    end
  endtask

  // Hold the output off while requests keep coming until the input stalls
  task automatic test_output_backpressure();
    hold_off_pending = 1'b1;
    repeat (8) send_epoch($urandom);
  endtask

  task automatic test_drain_pause();
    repeat (10) send_epoch($urandom);
    in_tvalid <= 1'b0;
    wait_for_drain();
    repeat (10) send_epoch($urandom);
  endtask

  task automatic test_back_to_back(input int count);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    test_random_epochs(count);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_epochs(300);
    test_day_edges(200);
    test_output_backpressure();
    test_drain_pause();
    test_back_to_back(150);

    in_tvalid <= 1'b0;
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_dates.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
